// File: design/cna_pkg.sv
// ---------------------------------------------------------------------------
// cna_pkg
// Shared widths, opcodes, types and the saturation function of the complex ALU.
// ---------------------------------------------------------------------------
`default_nettype none

package cna_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int FW = 4;
  localparam int PW = 2 * DW;
  localparam int QW = DW + 1;

  localparam logic [FW-1:0] FN_ADD  = FW'(0);
  localparam logic [FW-1:0] FN_SUB  = FW'(1);
  localparam logic [FW-1:0] FN_MUL  = FW'(2);
  localparam logic [FW-1:0] FN_MULS = FW'(3);
  localparam logic [FW-1:0] FN_DIV  = FW'(4);
  localparam logic [FW-1:0] FN_DIVS = FW'(5);
  localparam logic [FW-1:0] FN_CONJ = FW'(6);
  localparam logic [FW-1:0] FN_MODSQ = FW'(7);
  localparam logic [FW-1:0] FN_EQ   = FW'(8);
  localparam logic [FW-1:0] FN_EQS  = FW'(9);

  typedef logic [FW-1:0] func_t;
  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [PW:0] wide_t;
  typedef logic [PW-1:0] mag_t;
  typedef logic [QW-1:0] quo_t;

  typedef struct packed {
    func_t func;
    word_t ar;
    word_t ai;
    word_t br;
    word_t bi;
    prod_t p0;
    prod_t p1;
    prod_t p2;
    prod_t p3;
    prod_t p4;
    prod_t p5;
  } prd_t;

  typedef struct packed {
    logic use_div;
    logic dz;
    logic eq;
    logic neg_re;
    logic neg_im;
  } side_t;

  typedef struct packed {
    side_t side;
    mag_t  mag_re;
    mag_t  mag_im;
    mag_t  den;
  } work_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } clip_t;

  function automatic clip_t clip(input logic neg, input mag_t m);
    clip_t c;
    c.sat = 1'b0;
    if (neg) begin
      if (m > (mag_t'(1) << (DW - 1))) begin
        c.sat = 1'b1;
        c.val = {1'b1, {(DW - 1){1'b0}}};
      end else begin
        c.val = word_t'(DW'(0) - m[DW-1:0]);
      end
    end else begin
      if (m > ((mag_t'(1) << (DW - 1)) - mag_t'(1))) begin
        c.sat = 1'b1;
        c.val = {1'b0, {(DW - 1){1'b1}}};
      end else begin
        c.val = word_t'(m[DW-1:0]);
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/cna_if.sv
// ---------------------------------------------------------------------------
// cna_req_if / cna_rsp_if
// Valid/ready channels for the operand words and the result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface cna_req_if import cna_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  word_t a_re;
  word_t a_im;
  word_t b_re;
  word_t b_im;

  modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cna_rsp_if import cna_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t res_re;
  word_t res_im;
  logic  is_equal;
  logic  div_zero;
  logic  saturated;

  modport source (output valid, res_re, res_im, is_equal, div_zero, saturated,
                  input ready);
  modport sink (input valid, res_re, res_im, is_equal, div_zero, saturated,
                output ready);
endinterface

`default_nettype wire

// File: design/cna_mult.sv
// ---------------------------------------------------------------------------
// cna_mult
// Operand register followed by the six registered partial products.
// ---------------------------------------------------------------------------
`default_nettype none

module cna_mult import cna_pkg::*; (
  input  wire   clk,
  input  wire   rst,
  input  wire   en,
  input  wire   in_v,
  input  func_t func,
  input  word_t ar,
  input  word_t ai,
  input  word_t br,
  input  word_t bi,
  output logic  out_v,
  output prd_t  prd
);

  logic  a_v;
  func_t a_func;
  word_t a_ar, a_ai, a_br, a_bi;
  prod_t p0_c, p1_c, p2_c, p3_c, p4_c, p5_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_v;
    end
  end

  // For the squared modulus, operand b is replaced by operand a.
  always_ff @(posedge clk) begin
    if (en) begin
      a_func <= func;
      a_ar   <= ar;
      a_ai   <= ai;
      a_br   <= (func == FN_MODSQ) ? ar : br;
      a_bi   <= (func == FN_MODSQ) ? ai : bi;
    end
  end

  assign p0_c = a_ar * a_br;
  assign p1_c = a_ai * a_bi;
  assign p2_c = a_ai * a_br;
  assign p3_c = a_ar * a_bi;
  assign p4_c = a_br * a_br;
  assign p5_c = a_bi * a_bi;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prd.func <= a_func;
      prd.ar   <= a_ar;
      prd.ai   <= a_ai;
      prd.br   <= a_br;
      prd.bi   <= a_bi;
      prd.p0   <= p0_c;
      prd.p1   <= p1_c;
      prd.p2   <= p2_c;
      prd.p3   <= p3_c;
      prd.p4   <= p4_c;
      prd.p5   <= p5_c;
    end
  end

endmodule

`default_nettype wire

// File: design/cna_prep.sv
// ---------------------------------------------------------------------------
// cna_prep
// Forms exact sums as sign and magnitude, the divisor and the flags.
// ---------------------------------------------------------------------------
`default_nettype none

module cna_prep import cna_pkg::*; (
  input  wire   clk,
  input  wire   rst,
  input  wire   en,
  input  wire   in_v,
  input  prd_t  prd,
  output logic  out_v,
  output work_t work
);

  wide_t s_re, s_im;
  logic  do_shift;
  logic  use_div, dz, eq, neg_re, neg_im;
  mag_t  m_re, m_im, den_c, den_sum;
  work_t work_next;

  assign den_sum = mag_t'(prd.p4) + mag_t'(prd.p5);

  always_comb begin
    s_re     = '0;
    s_im     = '0;
    do_shift = 1'b0;
    use_div  = 1'b0;
    dz       = 1'b0;
    eq       = 1'b0;
    den_c    = '0;
    case (prd.func)
      FN_ADD: begin
        s_re = wide_t'(prd.ar) + wide_t'(prd.br);
        s_im = wide_t'(prd.ai) + wide_t'(prd.bi);
      end
      FN_SUB: begin
        s_re = wide_t'(prd.ar) - wide_t'(prd.br);
        s_im = wide_t'(prd.ai) - wide_t'(prd.bi);
      end
      FN_MUL: begin
        s_re = wide_t'(prd.p0) - wide_t'(prd.p1);
        s_im = wide_t'(prd.p2) + wide_t'(prd.p3);
        do_shift = 1'b1;
      end
      FN_MULS: begin
        s_re = wide_t'(prd.p0);
        s_im = wide_t'(prd.p2);
        do_shift = 1'b1;
      end
      FN_DIV: begin
        s_re = wide_t'(prd.p0) + wide_t'(prd.p1);
        s_im = wide_t'(prd.p2) - wide_t'(prd.p3);
        den_c = den_sum;
        dz = (den_sum == '0);
        use_div = !dz;
      end
      FN_DIVS: begin
        s_re = wide_t'(prd.ar);
        s_im = wide_t'(prd.ai);
        den_c = prd.br[DW-1] ? mag_t'(wide_t'(0) - wide_t'(prd.br)) : mag_t'(prd.br);
        dz = (prd.br == '0);
        use_div = !dz;
      end
      FN_CONJ: begin
        s_re = wide_t'(prd.ar);
        s_im = wide_t'(0) - wide_t'(prd.ai);
      end
      FN_MODSQ: begin
        s_re = wide_t'(prd.p0) + wide_t'(prd.p1);
        do_shift = 1'b1;
      end
      FN_EQ: begin
        eq = (prd.ar == prd.br) && (prd.ai == prd.bi);
      end
      FN_EQS: begin
        eq = (prd.ar == prd.br) && (prd.ai == '0);
      end
      default: begin
        eq = 1'b0;
      end
    endcase
  end

  always_comb begin
    m_re = s_re[PW] ? mag_t'(wide_t'(0) - s_re) : mag_t'(s_re);
    m_im = s_im[PW] ? mag_t'(wide_t'(0) - s_im) : mag_t'(s_im);
    neg_re = s_re[PW];
    neg_im = s_im[PW];
    if (do_shift) begin
      m_re = m_re >> FB;
      m_im = m_im >> FB;
    end
    if (prd.func == FN_DIVS) begin
      neg_re = prd.ar[DW-1] ^ prd.br[DW-1];
      neg_im = prd.ai[DW-1] ^ prd.br[DW-1];
    end
    if (dz) begin
      m_re   = '0;
      m_im   = '0;
      neg_re = 1'b0;
      neg_im = 1'b0;
    end
    work_next.side.use_div = use_div;
    work_next.side.dz      = dz;
    work_next.side.eq      = eq;
    work_next.side.neg_re  = neg_re;
    work_next.side.neg_im  = neg_im;
    work_next.mag_re       = m_re;
    work_next.mag_im       = m_im;
    work_next.den          = den_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work <= work_next;
    end
  end

endmodule

`default_nettype wire

// File: design/cna_div.sv
// ---------------------------------------------------------------------------
// cna_div
// Pipelined restoring divider, one quotient bit per stage for both parts.
// ---------------------------------------------------------------------------
`default_nettype none

module cna_div import cna_pkg::*; (
  input  wire   clk,
  input  wire   rst,
  input  wire   en,
  input  wire   in_v,
  input  work_t work_in,
  output logic  out_v,
  output work_t work_out,
  output quo_t  q_re,
  output quo_t  q_im,
  output logic  ovf_re,
  output logic  ovf_im
);

  localparam int XW = PW + QW;

  logic  v_s  [QW+1];
  work_t w_s  [QW+1];
  mag_t  rr_s [QW+1];
  mag_t  ri_s [QW+1];
  quo_t  qr_s [QW+1];
  quo_t  qi_s [QW+1];
  logic  or_s [QW+1];
  logic  oi_s [QW+1];

  logic [XW-1:0] n_re_sh, n_im_sh, d_sh;

  assign n_re_sh = XW'(work_in.mag_re) << FB;
  assign n_im_sh = XW'(work_in.mag_im) << FB;
  assign d_sh    = XW'(work_in.den) << QW;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= in_v;
    end
  end

  // The quotient fits in QW bits unless the overflow flag is raised.
  always_ff @(posedge clk) begin
    if (en) begin
      w_s[0]  <= work_in;
      rr_s[0] <= work_in.mag_re >> (QW - FB);
      ri_s[0] <= work_in.mag_im >> (QW - FB);
      qr_s[0] <= '0;
      qi_s[0] <= '0;
      or_s[0] <= (n_re_sh >= d_sh);
      oi_s[0] <= (n_im_sh >= d_sh);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int I = QW - 1 - k;
    logic          bit_re, bit_im;
    logic [PW:0]   tr, ti;
    logic          ger, gei;

    if (I >= FB) begin : g_bit
      assign bit_re = w_s[k].mag_re[I-FB];
      assign bit_im = w_s[k].mag_im[I-FB];
    end else begin : g_zero
      assign bit_re = 1'b0;
      assign bit_im = 1'b0;
    end

    assign tr  = {rr_s[k], bit_re};
    assign ti  = {ri_s[k], bit_im};
    assign ger = (tr >= {1'b0, w_s[k].den});
    assign gei = (ti >= {1'b0, w_s[k].den});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w_s[k+1]  <= w_s[k];
        or_s[k+1] <= or_s[k];
        oi_s[k+1] <= oi_s[k];
        rr_s[k+1] <= ger ? PW'(tr - {1'b0, w_s[k].den}) : PW'(tr);
        ri_s[k+1] <= gei ? PW'(ti - {1'b0, w_s[k].den}) : PW'(ti);
        qr_s[k+1] <= {qr_s[k][QW-2:0], ger};
        qi_s[k+1] <= {qi_s[k][QW-2:0], gei};
      end
    end
  end

  assign out_v    = v_s[QW];
  assign work_out = w_s[QW];
  assign q_re     = qr_s[QW];
  assign q_im     = qi_s[QW];
  assign ovf_re   = or_s[QW];
  assign ovf_im   = oi_s[QW];

endmodule

`default_nettype wire

// File: design/complex_number_alu.sv
// ---------------------------------------------------------------------------
// complex_number_alu
// Complex-number ALU in signed Q16.16 with saturation and exact division.
// ---------------------------------------------------------------------------
//   Channel  Dir  Word
//   req      in   func, a_re, a_im, b_re, b_im
//   rsp      out  res_re, res_im, is_equal, div_zero, saturated
//
// One word is accepted per cycle unless rsp stalls; every word passes through
// the one-bit-per-stage divider.
// Reset clears only the valid bits of the stages.
// A stall on rsp freezes the whole pipeline; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module complex_number_alu import cna_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  cna_req_if.sink   req,
  cna_rsp_if.source rsp
);

  logic  en;
  logic  m_v, p_v, d_v;
  prd_t  prd;
  work_t pw, dw;
  quo_t  q_re, q_im;
  logic  ovf_re, ovf_im;
  mag_t  f_re, f_im;
  clip_t c_re, c_im;
  logic  o_v;

  assign en        = !o_v || rsp.ready;
  assign req.ready = en;

  cna_mult u_mult (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (req.valid),
    .func  (req.func),
    .ar    (req.a_re),
    .ai    (req.a_im),
    .br    (req.b_re),
    .bi    (req.b_im),
    .out_v (m_v),
    .prd   (prd)
  );

  cna_prep u_prep (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (m_v),
    .prd   (prd),
    .out_v (p_v),
    .work  (pw)
  );

  cna_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (p_v),
    .work_in  (pw),
    .out_v    (d_v),
    .work_out (dw),
    .q_re     (q_re),
    .q_im     (q_im),
    .ovf_re   (ovf_re),
    .ovf_im   (ovf_im)
  );

  always_comb begin
    f_re = dw.mag_re;
    f_im = dw.mag_im;
    if (dw.side.use_div) begin
      f_re = ovf_re ? '1 : mag_t'(q_re);
      f_im = ovf_im ? '1 : mag_t'(q_im);
    end
    c_re = clip(dw.side.neg_re, f_re);
    c_im = clip(dw.side.neg_im, f_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (en) begin
      o_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.res_re    <= c_re.val;
      rsp.res_im    <= c_im.val;
      rsp.is_equal  <= dw.side.eq;
      rsp.div_zero  <= dw.side.dz;
      rsp.saturated <= c_re.sat | c_im.sat;
    end
  end

  assign rsp.valid = o_v;

endmodule

`default_nettype wire

// File: sim/complex_number_alu_tb.sv
// ---------------------------------------------------------------------------
// complex_number_alu_tb
// Self-checking testbench for the complex-number ALU. Operand words are driven
// in random bursts, results are taken with random stalls, and every result is
// checked field by field against an in-order queue of predicted words.
// ---------------------------------------------------------------------------
`default_nettype none

module complex_number_alu_tb import cna_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    word_t re;
    word_t im;
    logic  eq;
    logic  dz;
    logic  sat;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t pending[$];
    int       errors;

    function automatic logic signed [63:0] clip_val(input logic neg,
                                                    input logic [127:0] m,
                                                    inout logic sat);
      logic [127:0] half;
      half = 128'd1 << (DW - 1);
      if (neg) begin
        if (m > half) begin
          sat = 1'b1;
          m = half;
        end
        return -$signed(m[63:0]);
      end
      if (m > half - 1) begin
        sat = 1'b1;
        m = half - 1;
      end
      return $signed(m[63:0]);
    endfunction

    function automatic logic [127:0] qdiv(input logic [127:0] num,
                                          input logic [127:0] den);
      logic [127:0] q;
      q = (num << FB) / den;
      if (q > (128'd1 << DW)) q = 128'd1 << DW;
      return q;
    endfunction

    function automatic alu_res_t compute(input func_t f, input word_t ar,
                                         input word_t ai, input word_t br,
                                         input word_t bi);
      alu_res_t r;
      logic signed [127:0] s1, s2, den;
      logic [127:0] m1, m2;
      r = '{re: '0, im: '0, eq: 1'b0, dz: 1'b0, sat: 1'b0};
      case (f)
        FN_ADD, FN_SUB, FN_MUL, FN_MULS, FN_MODSQ, FN_CONJ: begin
          case (f)
            FN_ADD: begin s1 = ar + br; s2 = ai + bi; end
            FN_SUB: begin s1 = ar - br; s2 = ai - bi; end
            FN_MUL: begin
              s1 = ar * br - ai * bi;
              s2 = ai * br + ar * bi;
            end
            FN_MULS: begin s1 = ar * br; s2 = ai * br; end
            FN_MODSQ: begin s1 = ar * ar + ai * ai; s2 = 0; end
            default: begin s1 = ar; s2 = -ai; end
          endcase
          m1 = s1 < 0 ? -s1 : s1;
          m2 = s2 < 0 ? -s2 : s2;
          if (f inside {FN_MUL, FN_MULS, FN_MODSQ}) begin
            m1 = m1 >> FB;
            m2 = m2 >> FB;
          end
          r.re = word_t'(clip_val(s1 < 0, m1, r.sat));
          r.im = word_t'(clip_val(s2 < 0, m2, r.sat));
        end
        FN_DIV: begin
          den = br * br + bi * bi;
          if (den == 0) r.dz = 1'b1;
          else begin
            s1 = ar * br + ai * bi;
            s2 = ai * br - ar * bi;
            m1 = s1 < 0 ? -s1 : s1;
            m2 = s2 < 0 ? -s2 : s2;
            r.re = word_t'(clip_val(s1 < 0, qdiv(m1, den), r.sat));
            r.im = word_t'(clip_val(s2 < 0, qdiv(m2, den), r.sat));
          end
        end
        FN_DIVS: begin
          if (br == 0) r.dz = 1'b1;
          else begin
            den = br < 0 ? -br : br;
            s1 = ar;
            s2 = ai;
            m1 = s1 < 0 ? -s1 : s1;
            m2 = s2 < 0 ? -s2 : s2;
            r.re = word_t'(clip_val((ar < 0) != (br < 0), qdiv(m1, den), r.sat));
            r.im = word_t'(clip_val((ai < 0) != (br < 0), qdiv(m2, den), r.sat));
          end
        end
        FN_EQ: r.eq = (ar == br) && (ai == bi);
        FN_EQS: r.eq = (ar == br) && (ai == 0);
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(input func_t f, input word_t ar, input word_t ai,
                             input word_t br, input word_t bi);
      pending.push_back(compute(f, ar, ai, br, bi));
    endfunction

    function void check_result(input word_t re, input word_t im, input logic eq,
                               input logic dz, input logic sat);
      alu_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h", $realtime, re, im);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (re !== e.re) begin
        $display("%0t: res_re expected %h actual %h", $realtime, e.re, re);
        errors++;
      end
      if (im !== e.im) begin
        $display("%0t: res_im expected %h actual %h", $realtime, e.im, im);
        errors++;
      end
      if (eq !== e.eq) begin
        $display("%0t: is_equal expected %b actual %b", $realtime, e.eq, eq);
        errors++;
      end
      if (dz !== e.dz) begin
        $display("%0t: div_zero expected %b actual %b", $realtime, e.dz, dz);
        errors++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated expected %b actual %b", $realtime, e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   stall_mode = 0;

  cna_req_if req ();
  cna_rsp_if rsp ();

  complex_number_alu uut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  alu_scoreboard board = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.func = FN_ADD;
    req.a_re = '0;
    req.a_im = '0;
    req.b_re = '0;
    req.b_im = '0;
    rsp.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst && req.valid && req.ready)
      board.note_input(req.func, req.a_re, req.a_im, req.b_re, req.b_im);
    if (!rst && rsp.valid && rsp.ready)
      board.check_result(rsp.res_re, rsp.res_im, rsp.is_equal, rsp.div_zero,
                         rsp.saturated);
  end

  always @(negedge clk) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom_range(0, 3) != 0);
      2: rsp.ready <= ($urandom_range(0, 1) != 0);
      default: rsp.ready <= ((cycles / 7) % 3 != 0);
    endcase
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      4: return word_t'($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
      5: return 32'sh0001_0000;
      default: return word_t'($urandom());
    endcase
  endfunction

  task automatic send_word(input func_t f, input word_t ar, input word_t ai,
                           input word_t br, input word_t bi);
    req.valid <= 1'b1;
    req.func <= f;
    req.a_re <= ar;
    req.a_im <= ai;
    req.b_re <= br;
    req.b_im <= bi;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic pause_line(input int n);
    req.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_random(input int n);
    func_t f;
    word_t ar, ai, br;
    int left;
    left = n;
    while (left > 0) begin
      for (int k = $urandom_range(1, 30); k > 0 && left > 0; k--) begin
        f = func_t'($urandom_range(0, 15) < 14 ? $urandom_range(0, 9)
                                               : $urandom_range(10, 15));
        ar = pick_word();
        ai = pick_word();
        br = pick_word();
        if (f inside {FN_EQ, FN_EQS} && $urandom_range(0, 1)) br = ar;
        send_word(f, ar, ai, br,
                  (f == FN_EQ && $urandom_range(0, 1)) ? ai : pick_word());
        left--;
      end
      if ($urandom_range(0, 2) != 0) pause_line($urandom_range(1, 12));
    end
    req.valid <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    func_t f;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_word(FN_ADD, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd1, -32'sd1);
    send_word(FN_SUB, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd1, -32'sd1);
    send_word(FN_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
    send_word(FN_MUL, 32'sh0002_0000, 32'sh0001_8000, -32'sh0000_4000, 32'sh0003_0000);
    send_word(FN_MULS, 32'sh7fff_ffff, -32'sd3, 32'sh8000_0000, '0);
    send_word(FN_DIV, 32'sh0001_0000, 32'sh0002_0000, '0, '0);
    send_word(FN_DIV, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd1, '0);
    send_word(FN_DIV, 32'sh0003_0000, -32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000);
    send_word(FN_DIVS, 32'sh0001_0000, -32'sd7, '0, 32'sd5);
    send_word(FN_DIVS, 32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, '0);
    send_word(FN_DIVS, -32'sh0005_0000, 32'sh0007_0000, 32'sh0003_0000, '0);
    send_word(FN_CONJ, 32'sh1234_5678, 32'sh8000_0000, '0, '0);
    send_word(FN_CONJ, -32'sd9, 32'sh7fff_ffff, '0, '0);
    send_word(FN_MODSQ, 32'sh8000_0000, 32'sh8000_0000, '0, '0);
    send_word(FN_MODSQ, 32'sh0001_0000, -32'sh0002_0000, '0, '0);
    send_word(FN_EQ, 32'sd5, -32'sd5, 32'sd5, -32'sd5);
    send_word(FN_EQ, 32'sd5, -32'sd5, 32'sd5, 32'sd5);
    send_word(FN_EQS, 32'sd5, '0, 32'sd5, 32'sd9);
    send_word(FN_EQS, 32'sd5, 32'sd1, 32'sd5, '0);
    for (int u = 10; u < 16; u++) begin
      f = func_t'(u);
      send_word(f, 32'sh7fff_ffff, -32'sd1, 32'sh8000_0000, 32'sd3);
    end
    req.valid <= 1'b0;
    drain();
    send_random(900);
    drain();
    send_random(950);
    drain();
    repeat (60) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
design/cna_pkg.sv
design/cna_if.sv
design/cna_mult.sv
design/cna_prep.sv
design/cna_div.sv
design/complex_number_alu.sv
sim/complex_number_alu_tb.sv
